FILE: src/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants of the spectrogram column plotter
// Field widths, register codes, sequencer states and the pixel mapping.
// ----------------------------------------------------------------------------
package scp_pkg;

   localparam int DEF_MAX_ROWS    = 256;
   localparam int DEF_MAX_COLUMNS = 512;
   localparam int DEF_MAX_BINS    = 4096;

   localparam int MAG_W      = 16;
   localparam int READ_ROW_W = 8;
   localparam int READ_COL_W = 9;
   localparam int PIX_W      = 8;

   localparam int BIN_W      = 13;
   localparam int ROWS_W     = 9;
   localparam int COLS_W     = 10;
   localparam int MARK_W     = 9;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [BIN_W-1:0]  BIN_COUNT_RST    = 13'd512;
   localparam logic [ROWS_W-1:0] ROWS_USED_RST    = 9'd256;
   localparam logic [COLS_W-1:0] COLUMNS_USED_RST = 10'd512;

   localparam logic [BIN_W-1:0]  COUNTER_MAX = 13'd8191;

   localparam int GAIN    = 3 * 127;
   localparam int GAIN_SQ = GAIN * GAIN;
   localparam int PIX_BASE = 128;
   localparam int PIX_CAP  = 127;
   localparam int PIX_MARK = 255;

   localparam int MUL_A_W  = 18;
   localparam int MUL_B_W  = 16;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int OPND_W   = ROWS_W + BIN_W;
   localparam int RES_W    = 13;
   localparam int ROOT_W   = 9;
   localparam int REM_W    = 12;
   localparam int STEP_W   = 4;
   localparam int DIV_STEPS  = 13;
   localparam int SQRT_STEPS = 9;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIN_COUNT    = 3'd0,
      CSR_ROWS_USED    = 3'd1,
      CSR_COLUMNS_USED = 3'd2,
      CSR_COMBINE_BINS = 3'd3,
      CSR_START_COLUMN = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_MEM,
      ST_RD_OUT,
      ST_BIN_EVAL,
      ST_MUL_PIX,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_MUL_END,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_BIN_DONE,
      ST_FILL
   } state_type;

   typedef enum logic {
      OP_DIV,
      OP_SQRT
   } iter_op_type;

   typedef struct packed {
      logic              start;
      iter_op_type       op;
      logic [OPND_W-1:0] operand;
      logic [ROWS_W-1:0] divisor;
   } iter_cmd_type;

   typedef struct packed {
      logic             done;
      logic [RES_W-1:0] result;
   } iter_sts_type;

   // 128 + min(127, root)
   function automatic logic [PIX_W-1:0] pixel_of_root(logic [ROOT_W-1:0] root);
      logic [6:0] y;
      y = (root > ROOT_W'(PIX_CAP)) ? 7'(PIX_CAP) : root[6:0];
      return PIX_W'(PIX_BASE) + {1'b0, y};
   endfunction

endpackage

FILE: src/scp_if.sv
// ----------------------------------------------------------------------------
// scp_if: request and response channels of the spectrogram column plotter
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface scp_req_if import scp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [MAG_W-1:0]      magnitude;
   logic                  last_bin;
   logic [READ_ROW_W-1:0] read_row;
   logic [READ_COL_W-1:0] read_column;

   modport source (output valid, output req_type, output magnitude, output last_bin,
                   output read_row, output read_column, input ready);
   modport sink   (input valid, input req_type, input magnitude, input last_bin,
                   input read_row, input read_column, output ready);
endinterface

interface scp_rsp_if import scp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

FILE: src/scp_iter_unit.sv
// ----------------------------------------------------------------------------
// scp_iter_unit: shared shift-and-subtract unit
// Restoring division (13 quotient bits) or integer square root (9 root bits),
// one compare/subtract per cycle; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module scp_iter_unit import scp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  iter_cmd_type cmd,
   output iter_sts_type sts
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   iter_op_type       op_ff, op_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [OPND_W-1:0] src_ff, src_in;
   logic [RES_W-1:0]  res_ff, res_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [ROWS_W-1:0] div_ff, div_in;

   logic              sqrt_op;
   logic [REM_W-1:0]  shifted;
   logic [REM_W-1:0]  trial;
   logic [REM_W:0]    diff;
   logic              fits;

   always_comb begin
      sqrt_op = (op_ff == OP_SQRT);
      shifted = sqrt_op ? {rem_ff[REM_W-3:0], src_ff[OPND_W-1 -: 2]}
                        : {rem_ff[REM_W-2:0], src_ff[OPND_W-1]};
      trial   = sqrt_op ? {res_ff[REM_W-3:0], 2'b01}
                        : {{(REM_W-ROWS_W){1'b0}}, div_ff};
      diff    = {1'b0, shifted} - {1'b0, trial};
      fits    = ~diff[REM_W];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      rem_in  = rem_ff;
      src_in  = src_ff;
      res_in  = res_ff;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         res_in  = '0;
         div_in  = cmd.divisor;
         if (cmd.op == OP_SQRT) begin
            rem_in = '0;
            src_in = cmd.operand;
            cnt_in = STEP_W'(SQRT_STEPS - 1);
         end else begin
            rem_in = REM_W'(cmd.operand[OPND_W-1:RES_W]);
            src_in = {cmd.operand[RES_W-1:0], {(OPND_W-RES_W){1'b0}}};
            cnt_in = STEP_W'(DIV_STEPS - 1);
         end
      end else if (busy_ff) begin
         rem_in = fits ? diff[REM_W-1:0] : shifted;
         res_in = {res_ff[RES_W-2:0], fits};
         src_in = sqrt_op ? {src_ff[OPND_W-3:0], 2'b00} : {src_ff[OPND_W-2:0], 1'b0};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      rem_ff <= rem_in;
      src_ff <= src_in;
      res_ff <= res_in;
      cnt_ff <= cnt_in;
      div_ff <= div_in;
   end

   assign sts.done   = done_ff;
   assign sts.result = res_ff;

endmodule

FILE: src/spectrogram_column_plotter.sv
// ----------------------------------------------------------------------------
// spectrogram_column_plotter: scrolling spectrogram column painter
// req_ch carries either one FFT bin (req_type 0) or a pixel read (req_type 1).
// Bins of a frame paint one column of an internal MAX_ROWS x MAX_COLUMNS image
// at the marker column; bin 0 is skipped, each row takes the max of its bin
// range and maps it to 128 + min(127, sqrt(m) * 381 / 256). last_bin ends the frame:
// the marker advances (wrapping at columns_used) and that column is set to 255.
// A read returns one pixel on rsp_ch; a bin returns nothing.
// One item at a time: req_ch is ready only in ST_IDLE. A bin that paints no row
// goes through ST_BIN_EVAL and ST_BIN_DONE; bin 0 adds the division for the end of
// row 0. A bin that paints runs the 9-step root and then the 13-step division of
// the next row boundary on one shared subtract unit, or only the root when it
// paints the last row. Frame end then fills the new marker column row by row. A read
// goes through ST_RD_MEM, the registered image port and ST_RD_OUT to the rsp_ch register.
// Reset (synchronous) restores register defaults and then clears the image,
// one pixel a cycle over all MAX_ROWS*MAX_COLUMNS pixels (131072 by default);
// req_ch is not ready meanwhile, csr writes are taken at any time.
// rsp_ch has an output register: new items are taken while a pixel waits,
// and a further read holds until the waiting pixel is transferred.
// ----------------------------------------------------------------------------
module spectrogram_column_plotter import scp_pkg::*; #(
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_BINS    = DEF_MAX_BINS
) (
   input  logic                  clock,
   input  logic                  reset,
   scp_req_if.sink               req_ch,
   scp_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;
   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   state_type         state_ff, state_in;

   logic [BIN_W-1:0]  bin_count_ff, bin_count_in;
   logic [ROWS_W-1:0] rows_used_ff, rows_used_in;
   logic [COLS_W-1:0] columns_used_ff, columns_used_in;
   logic              combine_ff, combine_in;

   logic [MARK_W-1:0] marker_ff, marker_in;
   logic [BIN_W-1:0]  bin_cnt_ff, bin_cnt_in;
   logic [ROWS_W-1:0] cur_row_ff, cur_row_in;
   logic [MAG_W-1:0]  run_max_ff, run_max_in;
   logic [BIN_W-1:0]  row_end_ff, row_end_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;

   logic [MAG_W-1:0]      mag_ff, mag_in;
   logic                  last_ff, last_in;
   logic [READ_ROW_W-1:0] rd_row_ff, rd_row_in;
   logic [READ_COL_W-1:0] rd_col_ff, rd_col_in;
   logic                  rd_ok_ff, rd_ok_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_pixel_ff, rsp_pixel_in;

   logic [PIX_W-1:0]  img_mem [STORE_DEPTH];
   logic [PIX_W-1:0]  rd_data_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [PIX_W-1:0]  mem_wdata;
   logic [AW-1:0]     mem_raddr;

   iter_cmd_type      iter_cmd;
   iter_sts_type      iter_sts;

   logic              req_fire;
   logic              rsp_load;
   logic [BIN_W-1:0]  b_eff;
   logic [BIN_W-1:0]  bm1;
   logic [ROWS_W-1:0] h_eff;
   logic [COLS_W-1:0] w_eff;
   logic [ROWS_W-1:0] row_p1;
   logic              paint_hit;
   logic [COLS_W-1:0] marker_p1;
   logic [MARK_W-1:0] marker_next;
   logic [BIN_W-1:0]  end_raw;
   logic [BIN_W-1:0]  end_val;
   logic [MAG_W-1:0]  new_max;
   logic              wr_ok;
   logic [AW-1:0]     wr_addr;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;

   scp_iter_unit u_iter (
      .clock (clock),
      .reset (reset),
      .cmd   (iter_cmd),
      .sts   (iter_sts)
   );

   // effective geometry and shared datapath terms
   always_comb begin
      if (bin_count_ff < BIN_W'(2)) begin
         b_eff = BIN_W'(2);
      end else if (32'(bin_count_ff) > MAX_BINS) begin
         b_eff = BIN_W'(MAX_BINS);
      end else begin
         b_eff = bin_count_ff;
      end
      bm1 = b_eff - BIN_W'(1);

      if (rows_used_ff == '0) begin
         h_eff = ROWS_W'(1);
      end else if (32'(rows_used_ff) > MAX_ROWS) begin
         h_eff = ROWS_W'(MAX_ROWS);
      end else begin
         h_eff = rows_used_ff;
      end

      if (columns_used_ff == '0) begin
         w_eff = COLS_W'(1);
      end else if (32'(columns_used_ff) > MAX_COLUMNS) begin
         w_eff = COLS_W'(MAX_COLUMNS);
      end else begin
         w_eff = columns_used_ff;
      end

      row_p1      = cur_row_ff + ROWS_W'(1);
      paint_hit   = (cur_row_ff < h_eff) && (bin_cnt_ff == row_end_ff);
      new_max     = (mag_ff > run_max_ff) ? mag_ff : run_max_ff;
      marker_p1   = {1'b0, marker_ff} + COLS_W'(1);
      marker_next = (marker_p1 >= w_eff) ? '0 : marker_p1[MARK_W-1:0];
      end_raw     = combine_ff ? (iter_sts.result + BIN_W'(1)) : BIN_W'(row_p1);
      end_val     = (end_raw > bm1) ? bm1 : end_raw;

      wr_ok   = (32'(cur_row_ff) < MAX_ROWS) && (32'(marker_ff) < MAX_COLUMNS);
      wr_addr = AW'(32'(cur_row_ff) * MAX_COLUMNS + 32'(marker_ff));

      if (state_ff == ST_MUL_PIX) begin
         mul_a = MUL_A_W'(GAIN_SQ);
         mul_b = run_max_ff;
      end else begin
         mul_a = MUL_A_W'(row_p1);
         mul_b = MUL_B_W'(bm1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == AW'(STORE_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) state_in = req_ch.req_type ? ST_RD_MEM : ST_BIN_EVAL;
         end
         ST_RD_MEM: state_in = ST_RD_OUT;
         ST_RD_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) state_in = ST_IDLE;
         end
         ST_BIN_EVAL: begin
            if (bin_cnt_ff == '0) begin
               state_in = ST_MUL_END;
            end else if (paint_hit) begin
               state_in = ST_MUL_PIX;
            end else begin
               state_in = ST_BIN_DONE;
            end
         end
         ST_MUL_PIX: state_in = ST_SQRT_GO;
         ST_SQRT_GO: state_in = ST_SQRT_WAIT;
         ST_SQRT_WAIT: begin
            if (iter_sts.done) state_in = (row_p1 < h_eff) ? ST_MUL_END : ST_BIN_DONE;
         end
         ST_MUL_END: state_in = ST_DIV_GO;
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (iter_sts.done) state_in = ST_BIN_DONE;
         end
         ST_BIN_DONE: state_in = last_ff ? ST_FILL : ST_IDLE;
         ST_FILL: begin
            if (cur_row_ff == h_eff - ROWS_W'(1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      req_fire     = req_ch.valid && req_ch.ready;
      rsp_load     = (state_ff == ST_RD_OUT) && (!rsp_valid_ff || rsp_ch.ready);

      iter_cmd.start   = 1'b0;
      iter_cmd.op      = OP_DIV;
      iter_cmd.operand = prod_ff[OPND_W-1:0];
      iter_cmd.divisor = h_eff;

      mem_we    = 1'b0;
      mem_waddr = wr_addr;
      mem_wdata = PIX_W'(PIX_MARK);
      mem_raddr = rd_ok_ff ? AW'(32'(rd_row_ff) * MAX_COLUMNS + 32'(rd_col_ff)) : '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = '0;
         end
         ST_SQRT_GO: begin
            iter_cmd.start   = 1'b1;
            iter_cmd.op      = OP_SQRT;
            iter_cmd.operand = {prod_ff[PROD_W-1:MAG_W], {(OPND_W-(PROD_W-MAG_W)){1'b0}}};
         end
         ST_SQRT_WAIT: begin
            mem_we    = iter_sts.done && wr_ok;
            mem_wdata = pixel_of_root(iter_sts.result[ROOT_W-1:0]);
         end
         ST_DIV_GO: iter_cmd.start = 1'b1;
         ST_FILL: mem_we = wr_ok;
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      bin_count_in    = bin_count_ff;
      rows_used_in    = rows_used_ff;
      columns_used_in = columns_used_ff;
      combine_in      = combine_ff;
      marker_in       = marker_ff;
      bin_cnt_in      = bin_cnt_ff;
      cur_row_in      = cur_row_ff;
      run_max_in      = run_max_ff;
      row_end_in      = row_end_ff;
      clr_addr_in     = clr_addr_ff;
      mag_in          = mag_ff;
      last_in         = last_ff;
      rd_row_in       = rd_row_ff;
      rd_col_in       = rd_col_ff;
      rd_ok_in        = rd_ok_ff;
      prod_in         = prod_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_pixel_in    = rsp_pixel_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_BIN_COUNT:    bin_count_in    = csr_wdata[BIN_W-1:0];
            CSR_ROWS_USED:    rows_used_in    = csr_wdata[ROWS_W-1:0];
            CSR_COLUMNS_USED: columns_used_in = csr_wdata[COLS_W-1:0];
            CSR_COMBINE_BINS: combine_in      = csr_wdata[0];
            CSR_START_COLUMN: marker_in       = csr_wdata[MARK_W-1:0];
            default: begin
            end
         endcase
      end

      if (req_fire) begin
         mag_in    = req_ch.magnitude;
         last_in   = req_ch.last_bin;
         rd_row_in = req_ch.read_row;
         rd_col_in = req_ch.read_column;
         rd_ok_in  = (32'(req_ch.read_row) < MAX_ROWS) &&
                     (32'(req_ch.read_column) < MAX_COLUMNS);
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_pixel_in = rd_ok_ff ? rd_data_ff : '0;
      end

      case (state_ff)
         ST_CLEAR: clr_addr_in = clr_addr_ff + AW'(1);
         ST_BIN_EVAL: begin
            if (bin_cnt_ff == '0) begin
               run_max_in = '0;
               cur_row_in = '0;
            end else begin
               run_max_in = new_max;
            end
         end
         ST_MUL_PIX: prod_in = mul_a * mul_b;
         ST_MUL_END: prod_in = mul_a * mul_b;
         ST_SQRT_WAIT: begin
            if (iter_sts.done) begin
               cur_row_in = row_p1;
               run_max_in = combine_ff ? mag_ff : '0;
            end
         end
         ST_DIV_WAIT: begin
            if (iter_sts.done) row_end_in = end_val;
         end
         ST_BIN_DONE: begin
            bin_cnt_in = (bin_cnt_ff == COUNTER_MAX) ? bin_cnt_ff : bin_cnt_ff + BIN_W'(1);
            if (last_ff) begin
               marker_in  = marker_next;
               bin_cnt_in = '0;
               cur_row_in = '0;
               run_max_in = '0;
               row_end_in = '0;
            end
         end
         ST_FILL: begin
            cur_row_in = (cur_row_ff == h_eff - ROWS_W'(1)) ? '0 : row_p1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         bin_count_ff    <= BIN_COUNT_RST;
         rows_used_ff    <= ROWS_USED_RST;
         columns_used_ff <= COLUMNS_USED_RST;
         combine_ff      <= 1'b1;
         marker_ff       <= '0;
         bin_cnt_ff      <= '0;
         cur_row_ff      <= '0;
         run_max_ff      <= '0;
         row_end_ff      <= '0;
         clr_addr_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         bin_count_ff    <= bin_count_in;
         rows_used_ff    <= rows_used_in;
         columns_used_ff <= columns_used_in;
         combine_ff      <= combine_in;
         marker_ff       <= marker_in;
         bin_cnt_ff      <= bin_cnt_in;
         cur_row_ff      <= cur_row_in;
         run_max_ff      <= run_max_in;
         row_end_ff      <= row_end_in;
         clr_addr_ff     <= clr_addr_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      mag_ff       <= mag_in;
      last_ff      <= last_in;
      rd_row_ff    <= rd_row_in;
      rd_col_ff    <= rd_col_in;
      rd_ok_ff     <= rd_ok_in;
      prod_ff      <= prod_in;
      rsp_pixel_ff <= rsp_pixel_in;
   end

   // image store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         img_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= img_mem[mem_raddr];
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pixel_value = rsp_pixel_ff;

endmodule

FILE: tb/sv/tb_spectrogram_column_plotter.sv
// ----------------------------------------------------------------------------
// tb_spectrogram_column_plotter: self-checking bench of the column plotter
// Streams FFT frames and pixel reads through the request channel. A model of
// the image store, marker and row sequencer predicts every pixel read, and
// the result channel is compared in order. Both channels idle at random, and
// the bench steps through register settings including the clamped extremes.
// ----------------------------------------------------------------------------
module tb_spectrogram_column_plotter;
   import scp_pkg::*;

   localparam bit KIND_BIN  = 1'b0;
   localparam bit KIND_READ = 1'b1;
   localparam int ITEM_TARGET    = 370;
   localparam int SETTLE_CYCLES  = 400;
   localparam int OVERRUN_BINS   = 24;
   localparam int CYCLE_LIMIT    = 2000000;

   typedef struct {
      bit                  kind;
      bit [MAG_W-1:0]      magnitude;
      bit                  last_bin;
      bit [READ_ROW_W-1:0] read_row;
      bit [READ_COL_W-1:0] read_column;
   } plot_item_type;

   class plot_scoreboard_type;
      bit [PIX_W-1:0] image_px [DEF_MAX_ROWS*DEF_MAX_COLUMNS];
      int unsigned    bin_count_r    = BIN_COUNT_RST;
      int unsigned    rows_used_r    = ROWS_USED_RST;
      int unsigned    columns_used_r = COLUMNS_USED_RST;
      bit             combine_r      = 1'b1;
      int unsigned    marker;
      int unsigned    bin_index;
      int unsigned    row_now;
      int unsigned    peak;
      int unsigned    row_stop;
      bit [PIX_W-1:0] pending_pixels [$];
      int             failures;

      function void write_register(csr_index_type idx, int unsigned value);
         case (idx)
            CSR_BIN_COUNT:    bin_count_r    = value & 13'h1FFF;
            CSR_ROWS_USED:    rows_used_r    = value & 9'h1FF;
            CSR_COLUMNS_USED: columns_used_r = value & 10'h3FF;
            CSR_COMBINE_BINS: combine_r      = value[0];
            CSR_START_COLUMN: marker         = value & 9'h1FF;
            default: ;
         endcase
      endfunction

      function int unsigned bins_eff();
         if (bin_count_r < 2) return 2;
         if (bin_count_r > DEF_MAX_BINS) return DEF_MAX_BINS;
         return bin_count_r;
      endfunction

      function int unsigned rows_eff();
         if (rows_used_r < 1) return 1;
         if (rows_used_r > DEF_MAX_ROWS) return DEF_MAX_ROWS;
         return rows_used_r;
      endfunction

      function int unsigned cols_eff();
         if (columns_used_r < 1) return 1;
         if (columns_used_r > DEF_MAX_COLUMNS) return DEF_MAX_COLUMNS;
         return columns_used_r;
      endfunction

      // last bin of row x, clamped to the final bin
      function int unsigned row_last_bin(int unsigned x);
         int unsigned b;
         int unsigned e;
         b = bins_eff();
         if (combine_r) e = 1 + ((x + 1) * (b - 1)) / rows_eff();
         else e = x + 1;
         if (e > b - 1) e = b - 1;
         return e;
      endfunction

      // 128 + min(127, floor(sqrt(GAIN_SQ * m) / 256)), exact integer root
      function bit [PIX_W-1:0] pixel_of_magnitude(int unsigned m);
         longint unsigned n;
         longint unsigned r;
         longint unsigned t;
         int k;
         n = longint'(GAIN_SQ) * m;
         r = 0;
         for (k = 17; k >= 0; k--) begin
            t = r | (64'd1 << k);
            if (t * t <= n) r = t;
         end
         r = r >> 8;
         if (r > PIX_CAP) r = PIX_CAP;
         return PIX_W'(PIX_BASE + int'(r));
      endfunction

      function void take_item(plot_item_type it);
         int unsigned h;
         int unsigned w;
         int unsigned r;
         if (it.kind == KIND_READ) begin
            pending_pixels.push_back(image_px[it.read_row * DEF_MAX_COLUMNS + it.read_column]);
            return;
         end
         if (bin_index == 0) begin
            peak     = 0;
            row_now  = 0;
            row_stop = row_last_bin(0);
         end else begin
            h = rows_eff();
            if (it.magnitude > peak) peak = it.magnitude;
            if (row_now < h && bin_index == row_stop) begin
               image_px[row_now * DEF_MAX_COLUMNS + marker] = pixel_of_magnitude(peak);
               row_now++;
               peak = combine_r ? it.magnitude : 0;
               if (row_now < h) row_stop = row_last_bin(row_now);
            end
         end
         if (bin_index < COUNTER_MAX) bin_index++;
         if (it.last_bin) begin
            w = cols_eff();
            h = rows_eff();
            marker = (marker + 1 >= w) ? 0 : marker + 1;
            for (r = 0; r < h; r++) image_px[r * DEF_MAX_COLUMNS + marker] = PIX_MARK;
            bin_index = 0;
            row_now   = 0;
            peak      = 0;
            row_stop  = 0;
         end
      endfunction

      function void check_pixel(logic [PIX_W-1:0] pix);
         bit [PIX_W-1:0] want;
         if (pending_pixels.size() == 0) begin
            $error("pixel_value: no read pending, actual %0d", pix);
            failures++;
            return;
         end
         want = pending_pixels.pop_front();
         if (pix !== want) begin
            $error("pixel_value: expected %0d, actual %0d", want, pix);
            failures++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   bit                    steady;
   int unsigned           items_sent;
   int unsigned           cycles;
   plot_scoreboard_type   sb = new;

   scp_req_if req_ch ();
   scp_rsp_if rsp_ch ();

   spectrogram_column_plotter dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int unsigned draw_gap();
      return steady ? 0 : $urandom_range(0, 18);
   endfunction

   function automatic bit [MAG_W-1:0] pick_magnitude();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return MAG_W'($urandom_range(0, 255));
         default: return MAG_W'($urandom);
      endcase
   endfunction

   function automatic plot_item_type make_bin(bit [MAG_W-1:0] mag, bit closes);
      plot_item_type it;
      it.kind        = KIND_BIN;
      it.magnitude   = mag;
      it.last_bin    = closes;
      it.read_row    = READ_ROW_W'($urandom);
      it.read_column = READ_COL_W'($urandom);
      return it;
   endfunction

   function automatic plot_item_type make_read(int unsigned row, int unsigned col);
      plot_item_type it;
      it.kind        = KIND_READ;
      it.magnitude   = MAG_W'($urandom);
      it.last_bin    = $urandom_range(0, 1);
      it.read_row    = READ_ROW_W'(row);
      it.read_column = READ_COL_W'(col);
      return it;
   endfunction

   task automatic send_item(plot_item_type it);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= it.kind;
      req_ch.magnitude   <= it.magnitude;
      req_ch.last_bin    <= it.last_bin;
      req_ch.read_row    <= it.read_row;
      req_ch.read_column <= it.read_column;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.take_item(it);
      items_sent++;
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      sb.write_register(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // drain reads, then give a trailing bin or column fill time to finish
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_frame(int unsigned nbins, bit closes);
      int unsigned painted_col;
      int unsigned rows;
      int unsigned i;
      painted_col = sb.marker;
      for (i = 0; i < nbins; i++) begin
         send_item(make_bin(pick_magnitude(), closes && (i == nbins - 1)));
         if ($urandom_range(0, 7) == 0)
            send_item(make_read($urandom_range(0, 255), $urandom_range(0, 511)));
      end
      rows = sb.rows_eff();
      repeat ($urandom_range(1, 3))
         send_item(make_read($urandom_range(0, rows - 1), painted_col));
      send_item(make_read($urandom_range(0, rows - 1), sb.marker));
   endtask

   initial begin
      int unsigned rr;
      wait (reset === 1'b0);
      forever begin
         rr = draw_gap();
         if (rr != 0) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (rr - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         sb.check_pixel(rsp_ch.pixel_value);
      end
   end

   initial begin
      bit [MAG_W-1:0] ramp [8];
      int unsigned phase;
      int unsigned kind;
      int unsigned b;
      int unsigned h;
      int unsigned w;
      int unsigned start;
      int unsigned beff;
      int unsigned painted_col;
      int unsigned i;
      bit          comb;

      ramp = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0001,
               16'h4000, 16'h0001, 16'hFFFF, 16'h8000};
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      rsp_ch.ready       = 1'b0;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = KIND_BIN;
      req_ch.magnitude   = '0;
      req_ch.last_bin    = 1'b0;
      req_ch.read_row    = '0;
      req_ch.read_column = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset contents, frame end on bin 0, then one short frame cut early
      send_item(make_read(0, 0));
      send_item(make_read(255, 511));
      send_item(make_bin(16'hFFFF, 1'b1));
      send_item(make_read(255, 1));
      send_item(make_read(0, 0));
      for (i = 0; i < 8; i++) send_item(make_bin(ramp[i], i == 7));
      for (i = 0; i < 4; i++) send_item(make_read(i, 1));
      send_item(make_read(0, 2));
      send_item(make_read(200, 2));
      settle();

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         kind  = (phase < 8) ? phase : $urandom_range(0, 9);
         comb  = $urandom_range(0, 1);
         start = $urandom_range(0, 511);
         w     = $urandom_range(1, 512);
         case (kind)
            0: begin
               b = 8191; h = 511; w = 1023; comb = 1'b1; start = 511;
            end
            1: begin
               b = $urandom_range(0, 1); h = 0; w = 0; comb = 1'b0;
               start = $urandom_range(1, 511);
            end
            2: begin
               b = $urandom_range(2, 8); h = $urandom_range(b, 40);
            end
            3: begin
               b = 4096; h = 256; w = 512; comb = 1'b0;
            end
            4: begin
               b = $urandom_range(2, 40); h = $urandom_range(1, b - 1);
               w = $urandom_range(1, 4);
            end
            default: begin
               b = $urandom_range(2, 48); h = $urandom_range(1, b - 1);
            end
         endcase
         if (phase < 8 || $urandom_range(0, 9) < 7) write_reg(CSR_BIN_COUNT, b);
         if (phase < 8 || $urandom_range(0, 9) < 7) write_reg(CSR_ROWS_USED, h);
         if (phase < 8 || $urandom_range(0, 9) < 7) write_reg(CSR_COLUMNS_USED, w);
         if (phase < 8 || $urandom_range(0, 9) < 7) write_reg(CSR_COMBINE_BINS, comb);
         if (phase < 8 || $urandom_range(0, 9) < 4) write_reg(CSR_START_COLUMN, start);
         steady = ($urandom_range(0, 3) == 0);
         beff = sb.bins_eff();
         repeat ($urandom_range(1, 4)) begin
            if (items_sent < ITEM_TARGET) begin
               if (beff <= 64) begin
                  case ($urandom_range(0, 9))
                     0: run_frame(1, 1'b1);
                     1: run_frame($urandom_range(1, beff - 1), 1'b1);
                     2: run_frame(beff + $urandom_range(1, 4), 1'b1);
                     3: run_frame($urandom_range(1, beff), 1'b0);
                     default: run_frame(beff, 1'b1);
                  endcase
               end else begin
                  run_frame($urandom_range(1, 60), $urandom_range(0, 5) != 0);
               end
            end
         end
         settle();
         steady = 1'b0;
         phase++;
      end

      // bins past the final bin of a frame paint nothing new
      write_reg(CSR_BIN_COUNT, 2);
      write_reg(CSR_ROWS_USED, 1);
      write_reg(CSR_COMBINE_BINS, 1);
      steady = 1'b1;
      send_item(make_bin(16'h0000, 1'b1));
      painted_col = sb.marker;
      send_item(make_bin(16'h0000, 1'b0));
      send_item(make_bin(16'h0100, 1'b0));
      for (i = 0; i < OVERRUN_BINS; i++) send_item(make_bin(16'hFFFF, 1'b0));
      send_item(make_bin(16'hFFFF, 1'b1));
      steady = 1'b0;
      send_item(make_read(0, painted_col));
      send_item(make_read(0, sb.marker));
      settle();

      if (sb.failures == 0 && sb.pending_pixels.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
